FILE: rtl/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types, constants and code-table functions for the byte escape codec.
// ----------------------------------------------------------------------------
package bec_pkg;

  localparam logic [7:0] EscChar = 8'h3A;  // ':'
  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } out_t;

  // Translation of one input word: one or two result words
  typedef struct packed {
    out_t w0;
    out_t w1;
    logic two;
    logic pend;  // next escape_pending
  } xl_t;

  // Code character for a reserved byte, 0 when the byte passes through
  function automatic logic [7:0] enc_code(input logic [7:0] b);
    logic [7:0] c;
    c = 8'h00;
    if (b <= 8'h09) begin
      c = 8'h30 + b;
    end else begin
      case (b)
        8'h3A:   c = 8'h3A;
        8'h0A:   c = 8'h41;
        8'h0D:   c = 8'h42;
        8'h5E:   c = 8'h43;
        8'h7F:   c = 8'h44;
        8'hFF:   c = 8'h45;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // {known, original byte}; original is 0 for an unknown code
  function automatic logic [8:0] dec_code(input logic [7:0] c);
    logic [8:0] r;
    r = 9'h000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c - 8'h30};
    end else begin
      case (c)
        8'h3A:   r = {1'b1, 8'h3A};
        8'h41:   r = {1'b1, 8'h0A};
        8'h42:   r = {1'b1, 8'h0D};
        8'h43:   r = {1'b1, 8'h5E};
        8'h44:   r = {1'b1, 8'h7F};
        8'h45:   r = {1'b1, 8'hFF};
        default: r = 9'h000;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/bec_xlate.sv
// ----------------------------------------------------------------------------
// bec_xlate
// Maps one input word to its one or two result words (encode or decode).
// ----------------------------------------------------------------------------
module bec_xlate import bec_pkg::*; (
  input  mode_e mode_i,
  input  logic  pend_i,
  input  in_t   in_i,
  output xl_t   xl_o
);

  logic [7:0] code;
  logic [8:0] dec;

  assign code = enc_code(in_i.in_byte);
  assign dec  = dec_code(in_i.in_byte);

  always_comb begin
    xl_o      = '0;
    xl_o.two  = 1'b0;
    xl_o.pend = 1'b0;
    case (mode_i)
      MODE_ENC: begin
        if (code == 8'h00) begin
          xl_o.w0 = '{out_byte: in_i.in_byte, has_byte: 1'b1, out_last: in_i.in_last};
        end else begin
          xl_o.w0  = '{out_byte: EscChar, has_byte: 1'b1, out_last: 1'b0};
          xl_o.w1  = '{out_byte: code, has_byte: 1'b1, out_last: in_i.in_last};
          xl_o.two = 1'b1;
        end
      end
      MODE_DEC: begin
        if (pend_i) begin
          xl_o.w0 = '{out_byte: dec[7:0], has_byte: dec[8], out_last: in_i.in_last};
        end else if (in_i.in_byte == EscChar) begin
          // lone escape emits an empty word; last drops it
          xl_o.w0   = '{out_byte: 8'h00, has_byte: 1'b0, out_last: in_i.in_last};
          xl_o.pend = ~in_i.in_last;
        end else begin
          xl_o.w0 = '{out_byte: in_i.in_byte, has_byte: 1'b1, out_last: in_i.in_last};
        end
      end
      default: xl_o = '0;
    endcase
  end

endmodule

FILE: rtl/bec_queue.sv
// ----------------------------------------------------------------------------
// bec_queue
// Three-slot shift queue of result words; takes one or two words per push.
// ----------------------------------------------------------------------------
module bec_queue import bec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  xl_t  xl_i,
  output logic room_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  out_t             slot_q [QDepth];
  out_t             slot_d [QDepth];
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] base;
  logic             pop;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[0];
  // two free slots needed for a worst-case push
  assign room_o      = (cnt_q <= QCntW'(QDepth - 2));
  assign base        = cnt_q - QCntW'(pop);

  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      slot_d[i] = pop ? slot_q[i + 1] : slot_q[i];
    end
    slot_d[QDepth - 1] = slot_q[QDepth - 1];
    for (int i = 0; i < QDepth; i++) begin
      if (push_i && QCntW'(i) == base) begin
        slot_d[i] = xl_i.w0;
      end
      if (push_i && xl_i.two && QCntW'(i) == base + QCntW'(1)) begin
        slot_d[i] = xl_i.w1;
      end
    end
    cnt_d = cnt_q - QCntW'(pop);
    if (push_i) begin
      cnt_d = cnt_d + (xl_i.two ? QCntW'(2) : QCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

FILE: rtl/byte_escape_codec_core.sv
// ----------------------------------------------------------------------------
// byte_escape_codec_core
// Byte-stuffing escape codec: escapes reserved bytes as ':' + code (encode)
// or strips such escapes (decode), selected by the mode register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries {in_byte, in_last}; output
//   channel out_valid_o/out_ready_i carries {out_byte, has_byte, out_last}.
//   cfg_we_i writes cfg_wdata_i into mode (0 encode, 1 decode); write only
//   while the block is idle. A mode write leaves the escape flag alone.
//   An accepted word is translated in the accept cycle and lands in a
//   three-slot result queue; its first result shows there in the next cycle.
//   Throughput: one input word per cycle. In encode mode a reserved byte
//   yields two result words, so the output side sets the pace at one word
//   per cycle and input stalls while fewer than two slots are free.
//   A decode word always yields one result word, empty (has_byte 0) after a
//   lone ':' or an unknown escape code.
//   Reset empties the queue, clears the escape flag and selects encode.
//   When the receiver stalls, results wait in the queue and in_ready_o falls
//   once fewer than two slots remain; nothing is dropped.
// ----------------------------------------------------------------------------
module byte_escape_codec_core import bec_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  mode_e mode_q;
  logic  pend_q, pend_d;
  logic  accept;
  xl_t   xl;

  assign accept = in_valid_i && in_ready_o;
  assign pend_d = accept ? xl.pend : pend_q;

  bec_xlate u_xlate (
    .mode_i (mode_q),
    .pend_i (pend_q),
    .in_i   (in_data_i),
    .xl_o   (xl)
  );

  bec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .xl_i        (xl),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENC;
      pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      pend_q <= pend_d;
    end
  end

endmodule
